// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every clock edge, off during reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication checked on every clock edge, off during reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/topo_pkg.sv =====
// Package with shared types and constants of the topological sort block.
package topo_pkg;
  localparam int unsigned MaxNodes  = 32;
  localparam int unsigned MaxEdges  = 256;
  localparam int unsigned NodeW     = $clog2(MaxNodes);
  localparam int unsigned EdgeIdxW  = $clog2(MaxEdges);
  localparam int unsigned EdgeCntW  = EdgeIdxW + 1;
  localparam int unsigned CountW    = 6;
  localparam int unsigned DegW      = EdgeCntW;
  localparam int unsigned QDepth    = 2;

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_RUN = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_NODE   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  // One classified command travelling from front to back.
  typedef struct packed {
    cmd_e             cmd;
    logic             ok;
    logic [NodeW-1:0] src;
    logic [NodeW-1:0] dst;
  } op_t;
endpackage

// ===== rtl/core/topo_front.sv =====
// Front part: takes command beats, classifies edges and queues them for the back part.
module topo_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           command_i,
  input  logic [4:0]                     edge_source_i,
  input  logic [4:0]                     edge_target_i,
  input  logic [topo_pkg::CountW-1:0]    node_count_i,
  output topo_pkg::op_t                  op_o,
  output logic                           op_valid_o,
  input  logic                           op_pop_i
);
  localparam int unsigned PtrW = $clog2(topo_pkg::QDepth);

  topo_pkg::op_t            q_mem [topo_pkg::QDepth];
  logic [PtrW-1:0]          wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]            cnt_q, cnt_d;
  logic                     run_pend_q, run_pend_d;
  logic                     push;
  logic [topo_pkg::CountW-1:0] nc;
  topo_pkg::op_t            op_in;

  assign nc = (node_count_i > topo_pkg::CountW'(topo_pkg::MaxNodes)) ?
              topo_pkg::CountW'(topo_pkg::MaxNodes) : node_count_i;

  // Busy stays high from a run beat until the back part has finished it, and also while the queue is full.
  assign busy_o = run_pend_q || (cnt_q == (PtrW+1)'(topo_pkg::QDepth));
  assign push   = start_i && !busy_o;

  always_comb begin
    op_in.cmd = topo_pkg::cmd_e'(command_i);
    op_in.src = edge_source_i;
    op_in.dst = edge_target_i;
    op_in.ok  = ({1'b0, edge_source_i} < nc) && ({1'b0, edge_target_i} < nc);
  end

  assign op_o       = q_mem[rd_q];
  assign op_valid_o = cnt_q != '0;

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    run_pend_d = run_pend_q;
    if (push) begin
      wr_d = wr_q + 1'b1;
      if (op_in.cmd == topo_pkg::CMD_RUN) begin
        run_pend_d = 1'b1;
      end
    end
    if (op_pop_i) begin
      rd_d = rd_q + 1'b1;
      if (q_mem[rd_q].cmd == topo_pkg::CMD_RUN) begin
        run_pend_d = 1'b0;
      end
    end
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(op_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= op_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
      run_pend_q <= 1'b0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
      run_pend_q <= run_pend_d;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_no_pop_empty, op_pop_i, op_valid_o, "pop from empty queue")
  `ASSERT_CLK(a_cnt_range, cnt_q <= (PtrW+1)'(topo_pkg::QDepth), "queue count overflow")
  `ASSERT_IMPL(a_run_busy, push && command_i, ##1 busy_o, "run beat did not raise busy")
endmodule

// ===== rtl/core/topo_back.sv =====
// Back part: edge store, in-degree counts and the sequencer that runs the sort.
module topo_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  topo_pkg::op_t               op_i,
  input  logic                        op_valid_i,
  output logic                        op_pop_o,
  input  logic [topo_pkg::CountW-1:0] node_count_i,
  output logic                        valid_o,
  output logic                        kind_o,
  output logic [4:0]                  node_o,
  output logic                        ambiguous_o,
  output logic                        complete_o,
  output logic                        dropped_o,
  output logic                        last_o
);
  localparam int unsigned NW = topo_pkg::NodeW;
  localparam int unsigned EW = topo_pkg::EdgeIdxW;
  localparam int unsigned CW = topo_pkg::EdgeCntW;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SEED  = 7'b0000010,
    ST_POP   = 7'b0000100,
    ST_RD    = 7'b0001000,
    ST_EDGE  = 7'b0010000,
    ST_STAT  = 7'b0100000,
    ST_CLR   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [NW-1:0] from_mem [topo_pkg::MaxEdges];
  logic [NW-1:0] to_mem   [topo_pkg::MaxEdges];
  logic [NW-1:0] fifo_mem [topo_pkg::MaxNodes];
  logic [topo_pkg::DegW-1:0] deg_q [topo_pkg::MaxNodes];

  logic [CW-1:0] total_q;
  logic          drop_q;
  logic [NW:0]   head_q, tail_q;
  logic [NW:0]   idx_q;        // seed index and emitted count share nothing
  logic [NW:0]   emit_q;
  logic [CW-1:0] eidx_q;
  logic [NW-1:0] cur_q;
  logic          amb_q;
  logic [NW-1:0] rd_from_q, rd_to_q;
  logic          rd_vld_q;

  logic [topo_pkg::CountW-1:0] nc;
  logic do_add, do_run;
  logic edge_hit;
  logic push_seed, push_edge;
  logic emit_now, stat_now;

  assign nc = (node_count_i > topo_pkg::CountW'(topo_pkg::MaxNodes)) ?
              topo_pkg::CountW'(topo_pkg::MaxNodes) : node_count_i;

  assign do_add = (state_q == ST_IDLE) && op_valid_i && (op_i.cmd == topo_pkg::CMD_ADD);
  assign do_run = (state_q == ST_IDLE) && op_valid_i && (op_i.cmd == topo_pkg::CMD_RUN);
  // The run beat leaves the queue once the sort is over, which drops busy.
  assign op_pop_o = do_add || (state_q == ST_CLR);

  assign emit_now = (state_q == ST_POP) && (head_q < tail_q);
  assign stat_now = (state_q == ST_STAT);

  assign push_seed = (state_q == ST_SEED) && (idx_q < nc) &&
                     (deg_q[idx_q[NW-1:0]] == '0);
  assign edge_hit = rd_vld_q && (rd_from_q == cur_q) &&
                    ({1'b0, rd_to_q} < nc) && (deg_q[rd_to_q] != '0);
  assign push_edge = (state_q == ST_EDGE) && edge_hit &&
                     (deg_q[rd_to_q] == topo_pkg::DegW'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (do_run) state_d = ST_SEED;
      ST_SEED: if (idx_q >= nc) state_d = ST_POP;
      ST_POP:  state_d = (head_q < tail_q) ? ST_RD : ST_STAT;
      ST_RD:   state_d = ST_EDGE;
      ST_EDGE: if (!rd_vld_q) state_d = ST_POP;
      ST_STAT: state_d = ST_CLR;
      ST_CLR:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_add && op_i.ok && (total_q < CW'(topo_pkg::MaxEdges))) begin
      from_mem[total_q[EW-1:0]] <= op_i.src;
      to_mem[total_q[EW-1:0]]   <= op_i.dst;
    end
    rd_from_q <= from_mem[eidx_q[EW-1:0]];
    rd_to_q   <= to_mem[eidx_q[EW-1:0]];
    if (push_seed) begin
      fifo_mem[tail_q[NW-1:0]] <= idx_q[NW-1:0];
    end else if (push_edge && (tail_q < (NW+1)'(topo_pkg::MaxNodes))) begin
      fifo_mem[tail_q[NW-1:0]] <= rd_to_q;
    end
    if (state_q == ST_POP) begin
      cur_q <= fifo_mem[head_q[NW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      drop_q <= 1'b0;
      head_q <= '0;
      tail_q <= '0;
      idx_q <= '0;
      emit_q <= '0;
      eidx_q <= '0;
      amb_q <= 1'b0;
      rd_vld_q <= 1'b0;
      for (int i = 0; i < topo_pkg::MaxNodes; i++) deg_q[i] <= '0;
      valid_o <= 1'b0;
      kind_o <= 1'b0;
      node_o <= '0;
      ambiguous_o <= 1'b0;
      complete_o <= 1'b0;
      dropped_o <= 1'b0;
      last_o <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_o <= emit_now || stat_now;
      kind_o <= stat_now ? topo_pkg::KIND_STATUS : topo_pkg::KIND_NODE;
      node_o <= emit_now ? fifo_mem[head_q[NW-1:0]] : '0;
      ambiguous_o <= stat_now && amb_q;
      complete_o <= stat_now && (emit_q == nc);
      dropped_o <= stat_now && drop_q;
      last_o <= stat_now;
      if (do_add) begin
        if (op_i.ok && (total_q < CW'(topo_pkg::MaxEdges))) begin
          total_q <= total_q + 1'b1;
          deg_q[op_i.dst] <= deg_q[op_i.dst] + 1'b1;
        end else begin
          drop_q <= 1'b1;
        end
      end
      if (do_run) begin
        head_q <= '0;
        tail_q <= '0;
        idx_q <= '0;
        emit_q <= '0;
        amb_q <= 1'b0;
      end
      if (state_q == ST_SEED) begin
        idx_q <= idx_q + 1'b1;
        if (push_seed) tail_q <= tail_q + 1'b1;
      end
      if (emit_now) begin
        if ((tail_q - head_q) > (NW+1)'(1)) amb_q <= 1'b1;
        head_q <= head_q + 1'b1;
        emit_q <= emit_q + 1'b1;
        eidx_q <= '0;
      end
      // Read pipeline: address goes out one cycle, data is checked the next.
      if (state_q == ST_RD || state_q == ST_EDGE) begin
        rd_vld_q <= eidx_q < total_q;
        if (eidx_q < total_q) eidx_q <= eidx_q + 1'b1;
      end else begin
        rd_vld_q <= 1'b0;
      end
      if (state_q == ST_EDGE && edge_hit) begin
        deg_q[rd_to_q] <= deg_q[rd_to_q] - 1'b1;
        if (push_edge && (tail_q < (NW+1)'(topo_pkg::MaxNodes))) tail_q <= tail_q + 1'b1;
      end
      if (state_q == ST_CLR) begin
        total_q <= '0;
        drop_q <= 1'b0;
        for (int i = 0; i < topo_pkg::MaxNodes; i++) deg_q[i] <= '0;
      end
    end
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_head_le_tail, head_q <= tail_q, "fifo head passed tail")
  `ASSERT_CLK(a_total_range, total_q <= CW'(topo_pkg::MaxEdges), "edge count overflow")
  `ASSERT_IMPL(a_stat_last, state_q == ST_STAT, ##1 (valid_o && last_o), "status beat missing")
endmodule

// ===== rtl/core/topological_sort_unique_check_top.sv =====
// Top level of the topological sort block: front, command queue and back.
//
//  channel | direction | handshake                | payload
//  cmd     | in        | start, busy              | command_i, edge_source_i, edge_target_i
//  cfg     | in        | cfg_valid_i, cfg_ready_o | cfg_data_i (node_count)
//  result  | out       | valid_o strobe           | kind_o, node_o, ambiguous_o, complete_o,
//          |           |                          | dropped_o, last_o
//
// An add beat is taken by the back part while it is idle; edges stream at one per cycle
// while busy is low. A run beat seeds the nodes of in-degree zero, then walks the
// stored edges once for each node emitted; busy is high until it ends.
// Reset clears all counts and sets node_count to 32; no clearing pass is needed.
// Results are single-cycle strobes; the receiver cannot stall.
module topological_sort_unique_check_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       command_i,
  input  logic [4:0] edge_source_i,
  input  logic [4:0] edge_target_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_data_i,
  output logic       valid_o,
  output logic       kind_o,
  output logic [4:0] node_o,
  output logic       ambiguous_o,
  output logic       complete_o,
  output logic       dropped_o,
  output logic       last_o
);
  logic [topo_pkg::CountW-1:0] nc_q;
  topo_pkg::op_t op;
  logic op_valid, op_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q <= topo_pkg::CountW'(topo_pkg::MaxNodes);
    end else if (cfg_valid_i) begin
      nc_q <= cfg_data_i;
    end
  end

  topo_front u_front (
    .clk_i, .rst_ni,
    .start_i(start), .busy_o(busy),
    .command_i, .edge_source_i, .edge_target_i,
    .node_count_i(nc_q),
    .op_o(op), .op_valid_o(op_valid), .op_pop_i(op_pop)
  );

  topo_back u_back (
    .clk_i, .rst_ni,
    .op_i(op), .op_valid_i(op_valid), .op_pop_o(op_pop),
    .node_count_i(nc_q),
    .valid_o, .kind_o, .node_o, .ambiguous_o, .complete_o, .dropped_o, .last_o
  );
endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the Kahn topological sort block.
`timescale 1ns / 1ps

module testbench;
  localparam int unsigned WatchLimit = 200000;
  localparam int unsigned DrainWait  = 64;

  typedef struct packed {
    topo_pkg::kind_e kind;
    logic [4:0]      node;
    logic            ambiguous;
    logic            complete;
    logic            dropped;
    logic            last;
  } sort_out_t;

  typedef struct {
    topo_pkg::cmd_e cmd;
    logic [4:0]     src;
    logic [4:0]     dst;
    logic           typed;
    sort_out_t      want;
  } beat_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       command_i = 1'b0;
  logic [4:0] edge_source_i = '0;
  logic [4:0] edge_target_i = '0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [5:0] cfg_data_i = '0;
  logic       valid_o;
  logic       kind_o;
  logic [4:0] node_o;
  logic       ambiguous_o;
  logic       complete_o;
  logic       dropped_o;
  logic       last_o;

  topological_sort_unique_check_top dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the graph state.
  logic [5:0] node_limit;
  logic [4:0] arc_from [topo_pkg::MaxEdges];
  logic [4:0] arc_to   [topo_pkg::MaxEdges];
  int         arc_total;
  int         indeg    [topo_pkg::MaxNodes];
  logic       lost_arc;

  sort_out_t  order_q [$];
  int         errors;
  int         quiet_cycles;
  int         sender_gap_pct;

  function automatic int live_count();
    return (node_limit > topo_pkg::MaxNodes) ? int'(topo_pkg::MaxNodes) : int'(node_limit);
  endfunction

  task automatic forecast_beat(input topo_pkg::cmd_e cmd, input logic [4:0] s,
                               input logic [4:0] t);
    int nc, head, ordered;
    int ready [$];
    logic amb;
    sort_out_t r;
    nc = live_count();
    if (cmd == topo_pkg::CMD_ADD) begin
      if (s >= nc || t >= nc || arc_total >= topo_pkg::MaxEdges) begin
        lost_arc = 1'b1;
      end else begin
        arc_from[arc_total] = s;
        arc_to[arc_total] = t;
        arc_total++;
        indeg[t]++;
      end
      return;
    end
    amb = 1'b0;
    ordered = 0;
    for (int i = 0; i < nc; i++) if (indeg[i] == 0) ready = {ready, i};
    head = 0;
    while (head < ready.size()) begin
      if (ready.size() - head > 1) amb = 1'b1;
      r = '{topo_pkg::KIND_NODE, 5'(ready[head]), 1'b0, 1'b0, 1'b0, 1'b0};
      order_q = {order_q, r};
      ordered++;
      for (int e = 0; e < arc_total; e++) begin
        if (arc_from[e] != 5'(ready[head])) continue;
        if (arc_to[e] >= nc || indeg[arc_to[e]] == 0) continue;
        indeg[arc_to[e]]--;
        if (indeg[arc_to[e]] == 0) ready = {ready, int'(arc_to[e])};
      end
      head++;
    end
    r = '{topo_pkg::KIND_STATUS, 5'd0, amb, ordered == nc, lost_arc, 1'b1};
    order_q = {order_q, r};
    arc_total = 0;
    lost_arc = 1'b0;
    for (int i = 0; i < topo_pkg::MaxNodes; i++) indeg[i] = 0;
  endtask

  // Results are checked at the edge that ends their strobe cycle.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      sort_out_t want;
      if (order_q.size() == 0) begin
        $error("unexpected result beat node=%0d kind=%0d", node_o, kind_o);
        errors++;
      end else begin
        want = order_q.pop_front();
        if (kind_o != want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o); errors++;
        end
        if (node_o != want.node) begin
          $error("node: expected %0d, got %0d", want.node, node_o); errors++;
        end
        if (ambiguous_o != want.ambiguous) begin
          $error("ambiguous: expected %0d, got %0d", want.ambiguous, ambiguous_o); errors++;
        end
        if (complete_o != want.complete) begin
          $error("complete: expected %0d, got %0d", want.complete, complete_o); errors++;
        end
        if (dropped_o != want.dropped) begin
          $error("dropped: expected %0d, got %0d", want.dropped, dropped_o); errors++;
        end
        if (last_o != want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Start stays high after an accepted beat until the next beat or an idle cycle.
  task automatic send_beat(input topo_pkg::cmd_e cmd, input logic [4:0] s,
                           input logic [4:0] t);
    while ($urandom_range(99, 0) < sender_gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    edge_source_i <= s;
    edge_target_i <= t;
    do @(posedge clk_i); while (busy);
    forecast_beat(cmd, s, t);
  endtask

  task automatic write_node_count(input logic [5:0] value);
    start <= 1'b0;
    while (order_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    node_limit = value;
  endtask

  // Mostly small graphs with well-formed edges, then a run.
  task automatic random_graph();
    int nc, edges;
    nc = live_count();
    edges = $urandom_range(14, 0);
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(9, 0) == 0)
        send_beat(topo_pkg::CMD_ADD, 5'($urandom), 5'($urandom));
      else if ($urandom_range(3, 0) != 0) begin
        int a, b;
        a = $urandom_range(nc - 1, 0);
        b = $urandom_range(nc - 1, 0);
        if (a > b) begin int c; c = a; a = b; b = c; end
        if (a == b && $urandom_range(3, 0) != 0) continue;
        send_beat(topo_pkg::CMD_ADD, 5'(a), 5'(b));
      end else
        send_beat(topo_pkg::CMD_ADD, 5'($urandom_range(nc - 1, 0)),
                  5'($urandom_range(nc - 1, 0)));
    end
    send_beat(topo_pkg::CMD_RUN, 5'($urandom), 5'($urandom));
  endtask

  beat_row_t plan [$];

  initial begin
    node_limit = 6'd32;
    arc_total = 0;
    lost_arc = 1'b0;
    errors = 0;
    quiet_cycles = 0;
    sender_gap_pct = 10;
    for (int i = 0; i < topo_pkg::MaxNodes; i++) indeg[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at node_count 4, then 1, then 32 and 8.
    write_node_count(6'd4);
    plan = '{
      '{topo_pkg::CMD_RUN, 5'd0, 5'd0, 1'b0, '0},
      '{topo_pkg::CMD_ADD, 5'd0, 5'd1, 1'b0, '0},
      '{topo_pkg::CMD_ADD, 5'd1, 5'd2, 1'b0, '0},
      '{topo_pkg::CMD_ADD, 5'd2, 5'd3, 1'b0, '0},
      '{topo_pkg::CMD_ADD, 5'd31, 5'd0, 1'b0, '0},
      '{topo_pkg::CMD_RUN, 5'd31, 5'd31, 1'b0, '0},
      '{topo_pkg::CMD_ADD, 5'd1, 5'd1, 1'b0, '0},
      '{topo_pkg::CMD_ADD, 5'd0, 5'd2, 1'b0, '0},
      '{topo_pkg::CMD_RUN, 5'd0, 5'd0, 1'b0, '0},
      '{topo_pkg::CMD_ADD, 5'd3, 5'd2, 1'b0, '0},
      '{topo_pkg::CMD_ADD, 5'd2, 5'd3, 1'b0, '0},
      '{topo_pkg::CMD_RUN, 5'd0, 5'd0, 1'b0, '0}
    };
    foreach (plan[i]) send_beat(plan[i].cmd, plan[i].src, plan[i].dst);

    write_node_count(6'd1);
    plan = '{
      '{topo_pkg::CMD_ADD, 5'd0, 5'd1, 1'b0, '0},
      '{topo_pkg::CMD_RUN, 5'd0, 5'd0, 1'b1,
        '{topo_pkg::KIND_STATUS, 5'd0, 1'b0, 1'b1, 1'b1, 1'b1}},
      '{topo_pkg::CMD_ADD, 5'd0, 5'd0, 1'b0, '0},
      '{topo_pkg::CMD_RUN, 5'd0, 5'd0, 1'b1,
        '{topo_pkg::KIND_STATUS, 5'd0, 1'b0, 1'b0, 1'b0, 1'b1}}
    };
    foreach (plan[i]) begin
      send_beat(plan[i].cmd, plan[i].src, plan[i].dst);
      if (plan[i].typed && order_q[$] != plan[i].want) begin
        $error("status row %0d: expected %p, predicted %p", i, plan[i].want, order_q[$]);
        errors++;
      end
    end

    // Edges stored at full range, then a run with the range lowered below them.
    write_node_count(6'd32);
    send_beat(topo_pkg::CMD_ADD, 5'd0, 5'd31);
    send_beat(topo_pkg::CMD_ADD, 5'd31, 5'd1);
    write_node_count(6'd8);
    send_beat(topo_pkg::CMD_RUN, 5'd0, 5'd0);

    for (int phase = 0; phase < 3; phase++) begin
      sender_gap_pct = (phase == 0) ? 10 : (phase == 1) ? 82 : 0;
      for (int g = 0; g < 4; g++) begin
        case ($urandom_range(3, 0))
          0: write_node_count(6'($urandom_range(4, 1)));
          1: write_node_count(6'($urandom_range(12, 5)));
          2: write_node_count(6'd32);
          default: write_node_count(6'($urandom_range(63, 33)));
        endcase
        for (int k = 0; k < 2; k++) random_graph();
      end
    end

    start <= 1'b0;
    while (order_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
